[src/ptt_pkg.sv]
// ============================================================================
// ptt_pkg
// Shared types, constants and tables of the preintegrated transfer table.
// ============================================================================
package ptt_pkg;

    localparam int IDX_W  = 12;
    localparam int BYTE_W = 8;
    localparam int CSUM_W = 28;
    localparam int ASUM_W = 20;
    localparam int RAW_W  = 32;
    localparam int DIST_W = 24;
    localparam int P_W    = 32;

    // Divider geometry: widest dividend is P times a colour difference,
    // widest divisor is an opacity, longest quotient is the Q16 extinction.
    localparam int DVD_W = 60;
    localparam int DVS_W = 31;
    localparam int QUO_W = 21;
    localparam int QC_W  = 5;

    localparam int ACC_W = 31;
    localparam int X_W   = 21;
    localparam int LN_W  = 27;
    localparam int FRAC_W = 24;
    localparam int STEP_W = 5;

    localparam int EXP_STEPS     = 21;
    localparam int EXP_INT_STEPS = 5;
    localparam int LOG_STEPS     = 24;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [DIST_W-1:0] DIST_RESET = 24'd655;
    localparam logic [29:0]       LN2_Q30    = 30'd744261118;
    localparam logic [ACC_W-1:0]  ONE_Q30    = 31'h4000_0000;
    localparam logic [60:0]       HALF_Q30   = 61'h2000_0000;

    localparam logic [QC_W-1:0] QBITS_X = 5'd21;
    localparam logic [QC_W-1:0] QBITS_T = 5'd16;
    localparam logic [QC_W-1:0] QBITS_C = 5'd8;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
        logic [ASUM_W-1:0] alpha;
        logic [RAW_W-1:0]  raw;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [QC_W-1:0]  qbits;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_B,
        ST_RD_F,
        ST_SETUP,
        ST_XMUL,
        ST_XDIV,
        ST_LOG,
        ST_LNMUL,
        ST_PLNMUL,
        ST_EXP,
        ST_ALPHA,
        ST_CSET,
        ST_CMUL,
        ST_CDIV_T,
        ST_CDIV_C,
        ST_OUT
    } state_t;

    // Q30 factors of exp(-x): first the integer bits 1, 2, 4, 8, 16, then
    // the fraction bits from one half downward.
    function automatic logic [29:0] exp_const(input logic [STEP_W-1:0] step);
        logic [29:0] c;
        unique case (step)
            5'd0:    c = 30'd395007542;
            5'd1:    c = 30'd145315153;
            5'd2:    c = 30'd19666268;
            5'd3:    c = 30'd360200;
            5'd4:    c = 30'd121;
            5'd5:    c = 30'd651257337;
            5'd6:    c = 30'd836230973;
            5'd7:    c = 30'd947573834;
            5'd8:    c = 30'd1008687096;
            5'd9:    c = 30'd1040706261;
            5'd10:   c = 30'd1057095000;
            5'd11:   c = 30'd1065385899;
            5'd12:   c = 30'd1069555701;
            5'd13:   c = 30'd1071646719;
            5'd14:   c = 30'd1072693760;
            5'd15:   c = 30'd1073217664;
            5'd16:   c = 30'd1073479712;
            5'd17:   c = 30'd1073610760;
            5'd18:   c = 30'd1073676290;
            5'd19:   c = 30'd1073709056;
            5'd20:   c = 30'd1073725440;
            default: c = 30'd0;
        endcase
        return c;
    endfunction

    // Q24 log2 by repeated squaring; evaluated only on constants.
    function automatic longint unsigned log2_q24_fn(input int unsigned n);
        int unsigned     k;
        longint unsigned m;
        longint unsigned frac;
        k    = 0;
        frac = 0;
        for (int i = 1; i < 8; i++) begin
            if ((n >> i) != 0) begin
                k = i;
            end
        end
        m = 64'(n) << (30 - k);
        for (int i = 0; i < LOG_STEPS; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(k) << 24) | frac;
    endfunction

    localparam logic [LN_W-1:0] LOG2_255_Q24 = LN_W'(log2_q24_fn(255));

endpackage

[src/ptt_table_mem.sv]
// ============================================================================
// ptt_table_mem
// Single-port-write, registered-read memory holding one table entry per index.
// ============================================================================
module ptt_table_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  ptt_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output ptt_pkg::entry_t rd_data
);
    import ptt_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ptt_divider.sv]
// ============================================================================
// ptt_divider
// Restoring divider, one quotient bit per cycle, with a bounded quotient.
// A dividend of at least divisor times 2^qbits is flagged as saturated.
// ============================================================================
module ptt_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  ptt_pkg::div_req_t req,
    output ptt_pkg::div_rsp_t rsp
);
    import ptt_pkg::*;

    localparam int DSH_W = DVS_W + QUO_W;

    logic             busy_reg;
    logic             done_reg;
    logic             sat_reg;
    logic             first_reg;
    logic [QC_W-1:0]  cnt_reg;
    logic [DVD_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic             ge;

    assign ge = rem_reg >= DVD_W'(dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if ((first_reg && ge) || (!first_reg && cnt_reg == QC_W'(1)))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && req.start)
        begin
            rem_reg   <= req.dividend;
            dsh_reg   <= DSH_W'(req.divisor) << req.qbits;
            cnt_reg   <= req.qbits;
            quo_reg   <= '0;
            sat_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            if (first_reg)
            begin
                // The top compare only decides saturation.
                sat_reg   <= ge;
                first_reg <= 1'b0;
                dsh_reg   <= dsh_reg >> 1;
            end
            else
            begin
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - DVD_W'(dsh_reg);
                end
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - QC_W'(1);
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.sat      = sat_reg;
    assign rsp.quotient = quo_reg;

endmodule

[src/preintegrated_transfer_table_core.sv]
// ============================================================================
// preintegrated_transfer_table_core
// Builds a preintegrated transfer table from loaded RGBA colors and answers
// table-entry queries in fixed point.
// ============================================================================
// A load beat adds the alpha-premultiplied color to the running sums and
// writes sums and raw color into the entry memory at the back index; a load
// whose back index lies outside the table changes neither. A query beat
// reads the back and front entries from that memory, then runs a shared
// multiplier and a one-bit-per-cycle divider. Unequal indices with a
// matching alpha difference run one extinction division, up to 21 steps of
// the exponential, and per color channel up to two divisions. Equal indices
// whose back alpha is not 255 run 24 squaring steps of the logarithm and up
// to 21 exponential steps. A new beat is taken while the last result still
// waits on the output register. Configuration writes are to be made only
// while the block is idle; the block itself does not enforce this.
// ============================================================================
module preintegrated_transfer_table_core #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ptt_pkg::DIST_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [ptt_pkg::IDX_W-1:0]     back_index,
    input  logic [ptt_pkg::IDX_W-1:0]     front_index,
    input  logic [ptt_pkg::BYTE_W-1:0]    red_in,
    input  logic [ptt_pkg::BYTE_W-1:0]    green_in,
    input  logic [ptt_pkg::BYTE_W-1:0]    blue_in,
    input  logic [ptt_pkg::BYTE_W-1:0]    alpha_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ptt_pkg::BYTE_W-1:0]    blue_out,
    output logic [ptt_pkg::BYTE_W-1:0]    green_out,
    output logic [ptt_pkg::BYTE_W-1:0]    red_out,
    output logic [ptt_pkg::BYTE_W-1:0]    alpha_out,
    output logic [ptt_pkg::IDX_W-1:0]     row_out,
    output logic [ptt_pkg::IDX_W-1:0]     col_out
);
    import ptt_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int EXT_W = (AW > IDX_W) ? AW : IDX_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [DIST_W-1:0]  dist_reg;
    logic [CSUM_W-1:0]  run_r_reg, run_g_reg, run_b_reg;
    logic [ASUM_W-1:0]  run_a_reg;

    logic [IDX_W-1:0]   sb_reg, sf_reg;
    logic [P_W-1:0]     p_reg;
    entry_t             eb_reg, ef_reg;
    logic [ASUM_W-1:0]  ada_reg;
    logic [CSUM_W-1:0]  adc_reg;
    logic [19:0]        divx_reg;
    logic [CSUM_W-1:0]  divt_reg;
    logic               eq_reg;
    logic [X_W-1:0]     x_reg;
    logic               xsat_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   o_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [1:0]         ch_reg;
    logic [30:0]        m_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [2:0]         k_reg;
    logic [LN_W-1:0]    ln_reg;
    logic [BYTE_W-1:0]  res_r_reg, res_g_reg, res_b_reg, res_a_reg;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_r_reg, out_g_reg, out_b_reg, out_a_reg;
    logic [IDX_W-1:0]   out_row_reg, out_col_reg;

    // ------------------------------------------------------------------
    // Entry memory and load path
    // ------------------------------------------------------------------
    logic               in_beat, load_beat, query_beat;
    logic               in_range;
    logic [EXT_W-1:0]   back_ext, sf_ext;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    entry_t             wr_data, rd_data;
    logic [CSUM_W-1:0]  sum_r, sum_g, sum_b;
    logic [ASUM_W-1:0]  sum_a;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_beat    = in_valid && in_ready;
    assign load_beat  = in_beat && (opcode == OP_LOAD);
    assign query_beat = in_beat && (opcode == OP_QUERY);
    assign in_range   = 32'(back_index) < 32'(TABLE_DEPTH);
    assign back_ext   = EXT_W'(back_index);
    assign sf_ext     = EXT_W'(sf_reg);
    assign mem_we     = load_beat && in_range;

    assign sum_r = run_r_reg + CSUM_W'(alpha_in * red_in);
    assign sum_g = run_g_reg + CSUM_W'(alpha_in * green_in);
    assign sum_b = run_b_reg + CSUM_W'(alpha_in * blue_in);
    assign sum_a = run_a_reg + ASUM_W'(alpha_in);

    assign wr_data.red   = sum_r;
    assign wr_data.green = sum_g;
    assign wr_data.blue  = sum_b;
    assign wr_data.alpha = sum_a;
    assign wr_data.raw   = {alpha_in, blue_in, green_in, red_in};

    // The back entry is read on the query beat, the front entry in the cycle after it.
    assign rd_addr = (state_reg == ST_IDLE) ? back_ext[AW-1:0] : sf_ext[AW-1:0];

    ptt_table_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (back_ext[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Query setup terms
    // ------------------------------------------------------------------
    logic               sgt;
    logic               da_ok;
    logic [IDX_W-1:0]   adiff;
    logic [ASUM_W-1:0]  ada;
    logic [BYTE_W-1:0]  raw_a, log_n;
    logic [2:0]         log_k;
    logic [30:0]        m_init;

    assign sgt   = sb_reg > sf_reg;
    assign da_ok = (eb_reg.alpha != ef_reg.alpha) && ((eb_reg.alpha > ef_reg.alpha) == sgt);
    assign adiff = sgt ? (sb_reg - sf_reg) : (sf_reg - sb_reg);
    assign ada   = (eb_reg.alpha > ef_reg.alpha) ? (eb_reg.alpha - ef_reg.alpha)
                                                 : (ef_reg.alpha - eb_reg.alpha);
    assign raw_a = eb_reg.raw[31:24];
    assign log_n = 8'd255 - raw_a;

    always_comb
    begin
        log_k = 3'd0;
        for (int i = 1; i < 8; i++)
        begin
            if (log_n[i])
            begin
                log_k = 3'(i);
            end
        end
    end

    // The leading one of n lands on bit 30.
    assign m_init = 31'({23'd0, log_n} << (5'd30 - {2'd0, log_k}));

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [LN_W-1:0]    l_val;

    assign l_val = LOG2_255_Q24 - {k_reg, frac_reg};

    always_comb
    begin
        unique case (state_reg)
            ST_XMUL:   begin mul_a = p_reg;          mul_b = 32'(ada_reg);            end
            ST_EXP:    begin mul_a = 32'(acc_reg);   mul_b = 32'(exp_const(step_reg)); end
            ST_LOG:    begin mul_a = 32'(m_reg);     mul_b = 32'(m_reg);              end
            ST_LNMUL:  begin mul_a = 32'(l_val);     mul_b = 32'(LN2_Q30);            end
            ST_PLNMUL: begin mul_a = p_reg;          mul_b = 32'(ln_reg);             end
            ST_CMUL:   begin mul_a = p_reg;          mul_b = 32'(adc_reg);            end
            default:   begin mul_a = '0;             mul_b = '0;                      end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    ptt_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Channel terms
    // ------------------------------------------------------------------
    logic [CSUM_W-1:0]  pb, pf;
    logic               c_gt, c_ok;
    logic [CSUM_W-1:0]  adc;
    logic [29:0]        s_val;
    logic [37:0]        s255;
    logic               s_big;
    logic [38:0]        o255;
    logic [ACC_W-1:0]   o_val;
    logic               exp_bit;
    logic [STEP_W-1:0]  bit_idx;
    logic [31:0]        m2;
    logic [34:0]        x_full;

    always_comb
    begin
        unique case (ch_reg)
            2'd0:    begin pb = eb_reg.red;   pf = ef_reg.red;   end
            2'd1:    begin pb = eb_reg.green; pf = ef_reg.green; end
            default: begin pb = eb_reg.blue;  pf = ef_reg.blue;  end
        endcase
    end

    assign c_gt  = pb > pf;
    assign c_ok  = (pb != pf) && (c_gt == sgt);
    assign adc   = c_gt ? (pb - pf) : (pf - pb);
    assign s_val = {div_rsp.quotient[15:0], 14'd0};
    assign s255  = {s_val, 8'd0} - 38'(s_val);
    assign s_big = 31'(s_val) >= o_reg;
    assign o_val = ONE_Q30 - acc_reg;
    assign o255  = {o_val, 8'd0} - 39'(o_val);

    // Integer bits of x go first, then the fraction bits from the top down.
    assign bit_idx = (step_reg < STEP_W'(EXP_INT_STEPS)) ? (step_reg + 5'd16)
                                                         : (5'd20 - step_reg);
    assign exp_bit = x_reg[bit_idx];
    assign m2      = mul_p[61:30];
    assign x_full  = mul_p[58:24];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic               res_we;
    logic [BYTE_W-1:0]  res_val;
    logic               ch_adv;
    logic               out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.qbits    = QBITS_X;
        res_we           = 1'b0;
        res_val          = '0;
        ch_adv           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_beat)
                begin
                    state_next = ST_RD_B;
                end
            end
            ST_RD_B:
            begin
                state_next = ST_RD_F;
            end
            ST_RD_F:
            begin
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                if (sb_reg == sf_reg)
                begin
                    state_next = (raw_a == 8'd255) ? ST_OUT : ST_LOG;
                end
                else
                begin
                    state_next = da_ok ? ST_XMUL : ST_OUT;
                end
            end
            ST_XMUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[DVD_W-1:0];
                div_req.divisor  = DVS_W'(divx_reg);
                div_req.qbits    = QBITS_X;
                state_next       = ST_XDIV;
            end
            ST_XDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_EXP;
                end
            end
            ST_LOG:
            begin
                if (step_reg == STEP_W'(LOG_STEPS - 1))
                begin
                    state_next = ST_LNMUL;
                end
            end
            ST_LNMUL:
            begin
                state_next = ST_PLNMUL;
            end
            ST_PLNMUL:
            begin
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                if (xsat_reg || step_reg == STEP_W'(EXP_STEPS - 1))
                begin
                    state_next = ST_ALPHA;
                end
            end
            ST_ALPHA:
            begin
                state_next = (eq_reg || o_val == '0) ? ST_OUT : ST_CSET;
            end
            ST_CSET:
            begin
                if (c_ok)
                begin
                    state_next = ST_CMUL;
                end
                else
                begin
                    res_we = 1'b1;
                    ch_adv = 1'b1;
                end
            end
            ST_CMUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p[DVD_W-1:0];
                div_req.divisor  = DVS_W'(divt_reg);
                div_req.qbits    = QBITS_T;
                state_next       = ST_CDIV_T;
            end
            ST_CDIV_T:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.sat || s_big)
                    begin
                        res_we  = 1'b1;
                        res_val = 8'd255;
                        ch_adv  = 1'b1;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DVD_W'(s255);
                        div_req.divisor  = o_reg;
                        div_req.qbits    = QBITS_C;
                        state_next       = ST_CDIV_C;
                    end
                end
            end
            ST_CDIV_C:
            begin
                if (div_rsp.done)
                begin
                    res_we  = 1'b1;
                    res_val = div_rsp.quotient[BYTE_W-1:0];
                    ch_adv  = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ch_adv)
        begin
            state_next = (ch_reg == 2'd2) ? ST_OUT : ST_CSET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Control registers: distance, running sums, output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg      <= DIST_RESET;
            run_r_reg     <= '0;
            run_g_reg     <= '0;
            run_b_reg     <= '0;
            run_a_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dist_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                run_r_reg <= sum_r;
                run_g_reg <= sum_g;
                run_b_reg <= sum_b;
                run_a_reg <= sum_a;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_beat)
                begin
                    sb_reg <= back_index;
                    sf_reg <= front_index;
                    // 200 = 128 + 64 + 8
                    p_reg  <= (P_W'(dist_reg) << 7) + (P_W'(dist_reg) << 6)
                            + (P_W'(dist_reg) << 3);
                end
            end
            ST_RD_B:
            begin
                eb_reg <= (32'(sb_reg) < 32'(TABLE_DEPTH)) ? rd_data : '0;
            end
            ST_RD_F:
            begin
                ef_reg <= (32'(sf_reg) < 32'(TABLE_DEPTH)) ? rd_data : '0;
            end
            ST_SETUP:
            begin
                eq_reg    <= (sb_reg == sf_reg);
                ada_reg   <= ada;
                divx_reg  <= {adiff, 8'd0} - 20'(adiff);
                // 65025 = 65536 - 512 + 1
                divt_reg  <= (CSUM_W'(adiff) << 16) - (CSUM_W'(adiff) << 9)
                           + CSUM_W'(adiff);
                m_reg     <= m_init;
                k_reg     <= log_k;
                frac_reg  <= '0;
                step_reg  <= '0;
                if (sb_reg == sf_reg)
                begin
                    res_r_reg <= eb_reg.raw[7:0];
                    res_g_reg <= eb_reg.raw[15:8];
                    res_b_reg <= eb_reg.raw[23:16];
                    res_a_reg <= (p_reg != '0) ? 8'd255 : 8'd0;
                end
                else
                begin
                    res_r_reg <= '0;
                    res_g_reg <= '0;
                    res_b_reg <= '0;
                    res_a_reg <= '0;
                end
            end
            ST_XDIV:
            begin
                xsat_reg <= div_rsp.sat;
                x_reg    <= div_rsp.quotient;
                acc_reg  <= ONE_Q30;
                step_reg <= '0;
            end
            ST_LOG:
            begin
                frac_reg <= {frac_reg[FRAC_W-2:0], m2[31]};
                m_reg    <= m2[31] ? m2[31:1] : m2[30:0];
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_LNMUL:
            begin
                ln_reg <= mul_p[56:30];
            end
            ST_PLNMUL:
            begin
                xsat_reg <= |x_full[34:21];
                x_reg    <= x_full[20:0];
                acc_reg  <= ONE_Q30;
                step_reg <= '0;
            end
            ST_EXP:
            begin
                if (xsat_reg)
                begin
                    acc_reg <= '0;
                end
                else if (exp_bit)
                begin
                    acc_reg <= 31'((61'(mul_p) + HALF_Q30) >> 30);
                end
                step_reg <= step_reg + STEP_W'(1);
            end
            ST_ALPHA:
            begin
                o_reg     <= o_val;
                res_a_reg <= o255[37:30];
                ch_reg    <= 2'd0;
            end
            ST_CSET:
            begin
                adc_reg <= adc;
            end
            default:
            begin
            end
        endcase

        if (res_we)
        begin
            unique case (ch_reg)
                2'd0:    res_r_reg <= res_val;
                2'd1:    res_g_reg <= res_val;
                default: res_b_reg <= res_val;
            endcase
        end
        if (ch_adv)
        begin
            ch_reg <= ch_reg + 2'd1;
        end

        if (state_reg == ST_OUT && out_free)
        begin
            out_r_reg   <= res_r_reg;
            out_g_reg   <= res_g_reg;
            out_b_reg   <= res_b_reg;
            out_a_reg   <= res_a_reg;
            out_row_reg <= sb_reg;
            out_col_reg <= sf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = out_r_reg;
    assign green_out = out_g_reg;
    assign blue_out  = out_b_reg;
    assign alpha_out = out_a_reg;
    assign row_out   = out_row_reg;
    assign col_out   = out_col_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    a_query_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        query_beat |=> state_reg == ST_RD_B)
        else $error("query beat did not start the entry reads");

    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_XDIV || state_reg == ST_CDIV_T || state_reg == ST_CDIV_C)
         && !div_rsp.busy) |-> div_rsp.done)
        else $error("waiting on a divider that was never started");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");
`endif

endmodule
